### rtl/spl_pkg.sv
`default_nettype none

package spl_pkg;

  // operation codes of an input item
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // field width of the count reported in a result
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] weight;
    logic        [7:0]  tag;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic signed [31:0]   min_weight;
    logic        [7:0]    min_tag;
    logic signed [31:0]   max_weight;
    logic        [7:0]    max_tag;
  } out_item_t;

  // one stored entry
  typedef struct packed {
    logic signed [31:0] weight;
    logic        [7:0]  tag;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic signed [31:0] weight;
    logic        [7:0]  tag;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/spl_cell.sv
`default_nettype none

module spl_cell (
  input  wire                 clk,
  input  spl_pkg::cell_ctrl_t ctrl,
  input  wire                 occ,
  input  spl_pkg::entry_t     left_entry,
  input  wire                 left_gt,
  input  spl_pkg::entry_t     right_entry,
  input  wire                 seen_in,
  output spl_pkg::entry_t     entry,
  output logic                gt,
  output logic                seen_out
);
  import spl_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;

  // an empty cell orders after any new weight; equals keep arrival order
  assign gt       = !occ || ($signed(ctrl.weight) < $signed(entry_r.weight));
  assign match    = occ && (entry_r.tag == ctrl.tag);
  assign seen_out = seen_in || match;
  assign entry    = entry_r;

  // insert: take the new entry at the boundary, shift up above it
  // remove: shift down from the first matching cell on
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else begin
        entry_nxt.weight = ctrl.weight;
        entry_nxt.tag    = ctrl.tag;
      end
    end else if (ctrl.rem && seen_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

### rtl/sorted_priority_list_top.sv
// The row of cells, the count and the status are registered in an item's accept cycle;
// the result register is then loaded from them once the output is free.
// Throughput: one item per cycle while results are taken.
// An item is stalled while rst_n is low and while a finished result waits on a stalled output.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// entry contents are not cleared.
`default_nettype none

module sorted_priority_list_top #(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  spl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_stall,
  output spl_pkg::out_item_t out_item
);
  import spl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  status_t       status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          accept, load, full, found;
  cell_ctrl_t    ctrl;

  entry_t        cell_entry [DEPTH];
  logic          cell_gt    [DEPTH];
  logic          cell_seen  [DEPTH];
  logic          cell_occ   [DEPTH];
  logic          cell_last  [DEPTH];
  entry_t        max_entry;

  assign load     = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (busy_r && !load);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign found    = cell_seen[DEPTH-1];

  // broadcast the item to the row
  always_comb begin
    ctrl.ins    = accept && (in_item.func == FUNC_INSERT) && !full;
    ctrl.rem    = accept && (in_item.func == FUNC_REMOVE);
    ctrl.weight = in_item.weight;
    ctrl.tag    = in_item.tag;
  end

  // row of cells, occupied from the bottom up to the count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      spl_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (cell_occ[i]),
        .left_entry  ('0),
        .left_gt     (1'b0),
        .right_entry (cell_entry[i+1]),
        .seen_in     (1'b0),
        .entry       (cell_entry[i]),
        .gt          (cell_gt[i]),
        .seen_out    (cell_seen[i])
      );
    end else if (i == DEPTH - 1) begin : g_end
      spl_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (cell_occ[i]),
        .left_entry  (cell_entry[i-1]),
        .left_gt     (cell_gt[i-1]),
        .right_entry ('0),
        .seen_in     (cell_seen[i-1]),
        .entry       (cell_entry[i]),
        .gt          (cell_gt[i]),
        .seen_out    (cell_seen[i])
      );
    end else begin : g_mid
      spl_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (cell_occ[i]),
        .left_entry  (cell_entry[i-1]),
        .left_gt     (cell_gt[i-1]),
        .right_entry (cell_entry[i+1]),
        .seen_in     (cell_seen[i-1]),
        .entry       (cell_entry[i]),
        .gt          (cell_gt[i]),
        .seen_out    (cell_seen[i])
      );
    end

    // mark the highest occupied cell
    if (i == DEPTH - 1) begin : g_last_top
      assign cell_last[i] = cell_occ[i];
    end else begin : g_last_mid
      assign cell_last[i] = cell_occ[i] && !cell_occ[i+1];
    end
  end

  // pick the highest entry by its one-hot mark
  always_comb begin
    max_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_last[i]) begin
        max_entry = max_entry | cell_entry[i];
      end
    end
  end

  // status and count of the accepted item
  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    if (accept) begin
      if (in_item.func == FUNC_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          count_nxt  = count_r + CW'(1);
        end
      end else if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else if (!found) begin
        status_nxt = ST_NOTFOUND;
      end else begin
        status_nxt = ST_OK;
        count_nxt  = count_r - CW'(1);
      end
    end
  end

  // build the result from the updated row
  always_comb begin
    out_nxt = out_r;
    if (load) begin
      out_nxt.status = status_r;
      out_nxt.count  = COUNT_W'(count_r);
      if (count_r == '0) begin
        out_nxt.min_weight = '0;
        out_nxt.min_tag    = '0;
        out_nxt.max_weight = '0;
        out_nxt.max_tag    = '0;
      end else begin
        out_nxt.min_weight = cell_entry[0].weight;
        out_nxt.min_tag    = cell_entry[0].tag;
        out_nxt.max_weight = max_entry.weight;
        out_nxt.max_tag    = max_entry.tag;
      end
    end
  end

  // handshake control
  always_comb begin
    busy_nxt      = accept ? 1'b1 : (load ? 1'b0 : busy_r);
    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### rtl/spl_checker.sv
`default_nettype none

module spl_checker #(
  parameter int DEPTH = 16
) (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input spl_pkg::out_item_t out_item
);
  import spl_pkg::*;

  // an empty list reports zero extremes
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.count == '0 && DEPTH < 32) |->
      (out_item.min_weight == '0 && out_item.min_tag == '0 &&
       out_item.max_weight == '0 && out_item.max_tag == '0))
    else $error("empty result carries nonzero entries");

  // a refused insert reports a full list
  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |-> (out_item.count == COUNT_W'(DEPTH)))
    else $error("full status with count below depth");

  // a single entry is both lowest and highest
  a_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.count == COUNT_W'(1) && DEPTH < 32) |->
      (out_item.min_weight == out_item.max_weight && out_item.min_tag == out_item.max_tag))
    else $error("single entry has differing min and max");

  // hold a stalled result
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_list_top spl_checker #(.DEPTH(DEPTH)) u_spl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
